FILE: rtl/text_console_writer_top_assert.svh
// Assertion macros shared by the checker files of the text console writer.
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define TCW_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("text console writer assertion failed");

// Next-cycle implication, disabled while reset is low.
`define TCW_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text console writer assertion failed");

// Next-cycle implication that also holds across reset.
`define TCW_ASSERT_RST(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("text console writer assertion failed");

`endif

FILE: rtl/tcw_pkg.sv
// Package with the types, constants and helper functions of the text console writer.
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int CELLS    = COLUMNS * ROWS;
  localparam int CELL_AW  = $clog2(CELLS);
  localparam int TAB_STOP = 8;

  localparam int ACT_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 11;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int POS_W      = 11;
  localparam int DATA_W     = 16;
  localparam int ATTR_W     = 8;
  localparam int TOP_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam int COL_EXT_W = COL_W + 1;
  localparam int ROW_EXT_W = ROW_W + 1;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [CELL_AW-1:0] CELL_LAST     = CELL_AW'(CELLS - 1);
  localparam logic [CELL_AW-1:0] LAST_ROW_ADDR = CELL_AW'((ROWS - 1) * COLUMNS);

  localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_BS        = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PRINT_MIN = 8'h20;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTRIBUTE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_FREE_ROW = 1'b1;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;
  localparam logic [TOP_W-1:0]  TOP_RESET  = 5'd8;

  typedef enum logic [2:0] {
    K_NOP,
    K_BS,
    K_TAB,
    K_CR,
    K_LF,
    K_PUT,
    K_CLEAR,
    K_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [CHAR_W-1:0]   code;
    logic [CELL_AW-1:0]  index;
    logic                index_ok;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

  function automatic logic [CELL_AW-1:0] cell_addr(input logic [ROW_EXT_W-1:0] row,
                                                   input logic [COL_EXT_W-1:0] col);
    return CELL_AW'(row * COLUMNS + col);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tcw_in_if.sv
// Request channel interface carrying console commands into the writer.
`default_nettype none

interface tcw_in_if import tcw_pkg::*;;
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [CHAR_W-1:0]  char_code;
  logic [IDX_W-1:0]   cell_index;

  modport source (output valid, output action, output char_code, output cell_index,
                  input ready);
  modport sink   (input valid, input action, input char_code, input cell_index,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/tcw_out_if.sv
// Result channel interface carrying cursor state and read data out of the writer.
`default_nettype none

interface tcw_out_if import tcw_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COL_W-1:0]   cursor_col;
  logic [ROW_W-1:0]   cursor_row;
  logic [POS_W-1:0]   cursor_position;
  logic [DATA_W-1:0]  read_data;

  modport source (output valid, output cursor_col, output cursor_row,
                  output cursor_position, output read_data, input ready);
  modport sink   (input valid, input cursor_col, input cursor_row,
                  input cursor_position, input read_data, output ready);
endinterface

`default_nettype wire

FILE: rtl/tcw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/tcw_front.sv
// Front end: accepts requests and classifies them into engine commands.
`default_nettype none

module tcw_front import tcw_pkg::*; (
  tcw_in_if.sink          in_chan,
  input  wire back_stat_t stat,
  output      logic       push_valid,
  input  wire logic       push_ready,
  output      cmd_t       push_cmd
);

  assign in_chan.ready = push_ready && !stat.init_busy;
  assign push_valid    = in_chan.valid && !stat.init_busy;

  always_comb begin
    push_cmd.code     = in_chan.char_code;
    push_cmd.index    = CELL_AW'(in_chan.cell_index);
    push_cmd.index_ok = in_chan.cell_index < IDX_W'(CELLS);
    push_cmd.kind     = K_NOP;
    unique case (in_chan.action)
      ACT_PUT: begin
        unique case (in_chan.char_code)
          CH_BS:   push_cmd.kind = K_BS;
          CH_TAB:  push_cmd.kind = K_TAB;
          CH_LF:   push_cmd.kind = K_LF;
          CH_CR:   push_cmd.kind = K_CR;
          default: push_cmd.kind = (in_chan.char_code >= CH_PRINT_MIN) ? K_PUT : K_NOP;
        endcase
      end
      ACT_CLEAR: push_cmd.kind = K_CLEAR;
      ACT_READ:  push_cmd.kind = K_READ;
      default:   push_cmd.kind = K_NOP;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/tcw_cmdq.sv
// Short command queue between the front end and the engine.
`default_nettype none

module tcw_cmdq import tcw_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output      logic push_ready,
  input  wire cmd_t push_cmd,
  output      logic pop_valid,
  input  wire logic pop_ready,
  output      cmd_t pop_cmd
);

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = cnt_r != QCNT_W'(QDEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    cnt_nxt = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tcw_back.sv
// Engine: runs commands against the cell store, moves the cursor and emits results.
`default_nettype none

module tcw_back import tcw_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [ATTR_W-1:0] attribute,
  input  wire logic [TOP_W-1:0]  top_free_row,
  input  wire logic              pop_valid,
  output      logic              pop_ready,
  input  wire cmd_t              pop_cmd,
  output      back_stat_t        stat,
  tcw_out_if.source              out_chan
);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_SC_RD = 6'b001000,
    S_SC_WR = 6'b010000,
    S_FILL  = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [CELL_AW-1:0] ptr_r, ptr_nxt;
  logic               rd_ok_r, rd_ok_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COL_W-1:0]   out_col_r;
  logic [ROW_W-1:0]   out_row_r;
  logic [POS_W-1:0]   out_pos_r;
  logic [DATA_W-1:0]  out_data_r;

  logic               ram_we;
  logic [CELL_AW-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0]  ram_wdata, ram_rdata;

  logic [ROW_W-1:0]     top_row;
  logic [CELL_AW-1:0]   top_base;
  logic [DATA_W-1:0]    blank;
  logic [COL_EXT_W-1:0] col_e;
  logic [ROW_EXT_W-1:0] row_e;
  logic                 char_we;
  logic [CELL_AW-1:0]   char_waddr;
  logic [DATA_W-1:0]    char_wdata;
  logic                 scroll;
  logic                 out_free;
  logic                 emit;
  logic [DATA_W-1:0]    emit_data;

  assign top_row  = (top_free_row > TOP_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : ROW_W'(top_free_row);
  assign top_base = cell_addr({1'b0, top_row}, '0);
  assign blank    = {attribute, CH_BLANK};
  assign out_free = !out_valid_r || out_chan.ready;

  assign stat.init_busy = state_r == S_INIT;

  always_comb begin
    col_e      = {1'b0, col_r};
    row_e      = {1'b0, row_r};
    char_we    = 1'b0;
    char_waddr = cell_addr(row_e, col_e);
    char_wdata = blank;
    unique case (pop_cmd.kind)
      K_BS: begin
        if (!(col_r == '0 && (row_r == top_row || row_r == '0))) begin
          if (col_r == '0) begin
            col_e = COL_EXT_W'(COLUMNS - 1);
            row_e = row_e - ROW_EXT_W'(1);
          end else begin
            col_e = col_e - COL_EXT_W'(1);
          end
          char_we    = 1'b1;
          char_waddr = cell_addr(row_e, col_e);
        end
      end
      K_TAB: begin
        col_e = (col_e + COL_EXT_W'(TAB_STOP)) & ~COL_EXT_W'(TAB_STOP - 1);
      end
      K_CR: begin
        col_e = '0;
      end
      K_LF: begin
        col_e = '0;
        row_e = row_e + ROW_EXT_W'(1);
      end
      K_PUT: begin
        char_we    = 1'b1;
        char_wdata = {attribute, pop_cmd.code};
        col_e      = col_e + COL_EXT_W'(1);
      end
      default: begin
        col_e = {1'b0, col_r};
      end
    endcase
    if (col_e >= COL_EXT_W'(COLUMNS)) begin
      col_e = '0;
      row_e = row_e + ROW_EXT_W'(1);
    end
    scroll = row_e >= ROW_EXT_W'(ROWS);
  end

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    ptr_nxt   = ptr_r;
    rd_ok_nxt = rd_ok_r;
    ram_we    = 1'b0;
    ram_waddr = ptr_r;
    ram_wdata = blank;
    ram_raddr = ptr_r + CELL_AW'(COLUMNS);
    pop_ready = 1'b0;
    emit      = 1'b0;
    emit_data = '0;
    unique case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        if (ptr_r == CELL_LAST) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + CELL_AW'(1);
        end
      end
      S_IDLE: begin
        pop_ready = out_free;
        if (pop_valid && out_free) begin
          unique case (pop_cmd.kind)
            K_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = top_row;
              ptr_nxt   = top_base;
              state_nxt = S_FILL;
            end
            K_READ: begin
              ram_raddr = pop_cmd.index;
              rd_ok_nxt = pop_cmd.index_ok;
              state_nxt = S_READ;
            end
            default: begin
              ram_we    = char_we;
              ram_waddr = char_waddr;
              ram_wdata = char_wdata;
              col_nxt   = COL_W'(col_e);
              if (scroll) begin
                row_nxt = ROW_W'(ROWS - 1);
                if (top_row == ROW_W'(ROWS - 1)) begin
                  ptr_nxt   = LAST_ROW_ADDR;
                  state_nxt = S_FILL;
                end else begin
                  ptr_nxt   = top_base;
                  state_nxt = S_SC_RD;
                end
              end else begin
                row_nxt = ROW_W'(row_e);
                emit    = 1'b1;
              end
            end
          endcase
        end
      end
      S_READ: begin
        emit      = 1'b1;
        emit_data = rd_ok_r ? ram_rdata : '0;
        state_nxt = S_IDLE;
      end
      S_SC_RD: begin
        state_nxt = S_SC_WR;
      end
      S_SC_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        ptr_nxt   = ptr_r + CELL_AW'(1);
        state_nxt = (ptr_r == LAST_ROW_ADDR - CELL_AW'(1)) ? S_FILL : S_SC_RD;
      end
      S_FILL: begin
        ram_we = 1'b1;
        if (ptr_r == CELL_LAST) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + CELL_AW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = (out_valid_r && !out_chan.ready) || emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      col_r       <= '0;
      row_r       <= (TOP_RESET > TOP_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : ROW_W'(TOP_RESET);
      ptr_r       <= '0;
      rd_ok_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      ptr_r       <= ptr_nxt;
      rd_ok_r     <= rd_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_col_r  <= col_nxt;
      out_row_r  <= row_nxt;
      out_pos_r  <= POS_W'(cell_addr({1'b0, row_nxt}, {1'b0, col_nxt}));
      out_data_r <= emit_data;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.cursor_col      = out_col_r;
  assign out_chan.cursor_row      = out_row_r;
  assign out_chan.cursor_position = out_pos_r;
  assign out_chan.read_data       = out_data_r;

  tcw_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

FILE: rtl/text_console_writer_top.sv
// Top level of the text console writer: configuration registers and the front, queue and engine.
//
// Text console writer for an 80 by 25 screen of 16-bit cells (attribute byte high,
// character byte low) with a cursor. Each request gives exactly one result with the
// cursor after the request and, for a cell read, the cell contents. After reset the
// engine zeroes all 2000 cells, one per cycle, and in_chan.ready stays low while it
// does so; configuration writes are taken at any time. A printable character,
// control code or ignored code that does not scroll leaves the engine in the cycle
// after the engine takes it, and a cell read passes the read state first, since the
// cell store has a single write port and a registered read. Clearing the free rows
// writes one cell per cycle (all 2000 cells when the free rows start at row 0). A
// scroll copies each cell from the row below through a read and a write state, then
// blanks the bottom row. A two-entry request queue keeps accepting while the engine
// works and a result waits in the output register, until both entries are full.
`default_nettype none

module text_console_writer_top import tcw_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  tcw_in_if.sink                     in_chan,
  tcw_out_if.source                  out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [ATTR_W-1:0] attr_r;
  logic [TOP_W-1:0]  top_r;
  back_stat_t        stat;
  logic              push_valid, push_ready, pop_valid, pop_ready;
  cmd_t              push_cmd, pop_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
      top_r  <= TOP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ATTRIBUTE:    attr_r <= ATTR_W'(cfg_data);
        CFG_TOP_FREE_ROW: top_r  <= cfg_data[TOP_W-1:0];
        default:          attr_r <= attr_r;
      endcase
    end
  end

  tcw_front u_front (
    .in_chan    (in_chan),
    .stat       (stat),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  tcw_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  tcw_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .attribute    (attr_r),
    .top_free_row (top_r),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_cmd      (pop_cmd),
    .stat         (stat),
    .out_chan     (out_chan)
  );

endmodule

`default_nettype wire

FILE: rtl/tcw_checker.sv
// Port-level checker for the text console writer and its bind to the top level.
`default_nettype none
`include "text_console_writer_top_assert.svh"

module tcw_port_checker import tcw_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [COL_W-1:0]  out_col,
  input wire logic [ROW_W-1:0]  out_row,
  input wire logic [POS_W-1:0]  out_pos,
  input wire logic [DATA_W-1:0] out_data
);

  logic [2:0] pending_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + 3'(in_acc) - 3'(out_acc);
    end
  end

  `TCW_ASSERT_RST(a_init_holds_off, !rst_n, !in_ready)
  `TCW_ASSERT_IMP(a_no_unrequested_result, out_valid, pending_r != '0)
  `TCW_ASSERT_IMP(a_bounded_in_flight, 1'b1, pending_r <= 3'(QDEPTH + 1))
  `TCW_ASSERT_IMP(a_position_matches, out_valid,
                  out_pos == POS_W'(cell_addr({1'b0, out_row}, {1'b0, out_col})))
  `TCW_ASSERT_NEXT(a_result_held, out_valid && !out_ready,
                   out_valid && $stable(out_pos) && $stable(out_data))

endmodule

bind text_console_writer_top tcw_port_checker u_tcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_col   (out_chan.cursor_col),
  .out_row   (out_chan.cursor_row),
  .out_pos   (out_chan.cursor_position),
  .out_data  (out_chan.read_data)
);

`default_nettype wire
